// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define CWIC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// checked at every edge, reset included
`define CWIC_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/cwic_pkg.sv
package cwic_pkg;

	// status word fields
	localparam logic [31:0] ST_BASE    = 32'h8000_001a;
	localparam logic [31:0] ST_WHEEL   = 32'h4000_0000;
	localparam logic [31:0] ST_PENDING = 32'h0c00_0000;
	localparam logic [2:0]  MENU_CODE  = 3'd4;

	// word addresses inside the bus window
	localparam logic [5:0] WADDR_POP     = 6'h00;
	localparam logic [5:0] WADDR_PENDING = 6'h01;
	localparam logic [5:0] WADDR_STATUS  = 6'h10;

	// access size codes
	localparam logic [2:0] SIZE_BYTE = 3'd1;
	localparam logic [2:0] SIZE_HALF = 3'd2;

	// configuration register address
	localparam logic [1:0] CFG_ADDR_HOLD = 2'b00;

	localparam int DEADLINE_W = 49;

	typedef enum logic [2:0] {
		KIND_READ   = 3'd0,
		KIND_WRITE  = 3'd1,
		KIND_BUTTON = 3'd2,
		KIND_TAP    = 3'd3,
		KIND_WHEEL  = 3'd4,
		KIND_RELALL = 3'd5,
		KIND_TICK   = 3'd6
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_WRITE_REG,
		OP_POP,
		OP_BUTTON,
		OP_TAP_RELEASE,
		OP_TAP_PRESS,
		OP_WHEEL,
		OP_RELEASE_ALL,
		OP_TICK,
		OP_READ_OUT
	} op_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         offset;
		logic [2:0]         access_size;
		logic [31:0]        write_data;
		logic [2:0]         button;
		logic               pressed;
		logic [31:0]        tap_ticks;
		logic signed [7:0]  wheel_delta;
		logic               in_standby;
		logic [47:0]        now_tick;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        accepted;
		logic        wake_request;
		logic        irq;
		logic [3:0]  pending_count;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		op_t  op;
		logic finish;
		logic accepted;
		logic wake;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] kind;
		logic       btn_ok;
		logic       wake_cond;
		logic       win_ok;
		logic       pop_addr;
		logic       tap_pending;
		logic       tick_due;
		logic       held_any;
	} sts_t;

endpackage

// File: rtl/core/cwic_cfg.sv
module cwic_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        hold
);

	logic hold_q;
	logic hit;

	assign hit    = (paddr == cwic_pkg::CFG_ADDR_HOLD);
	assign pready = 1'b1;

	// hold switch register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (psel && penable && pwrite && hit) begin
			hold_q <= pwdata[0];
		end
	end

	// read back
	assign prdata = hit ? {31'b0, hold_q} : '0;
	assign hold   = hold_q;

endmodule

// File: rtl/core/cwic_ctrl.sv
`include "assert_macros.svh"

module cwic_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            hold,
	input  cwic_pkg::sts_t  sts,
	output logic            busy,
	output cwic_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_TAP2
	} state_t;

	state_t state_q, state_d;

	// next state and datapath commands
	always_comb begin
		cmd      = '0;
		cmd.op   = cwic_pkg::OP_NONE;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d    = S_IDLE;
				cmd.finish = 1'b1;
				case (sts.kind) inside
					cwic_pkg::KIND_READ: begin
						// register file and queue reads land next cycle
						cmd.finish = 1'b0;
						state_d    = S_READ;
					end
					cwic_pkg::KIND_WRITE: begin
						if (sts.win_ok) begin
							cmd.op = sts.pop_addr ? cwic_pkg::OP_POP : cwic_pkg::OP_WRITE_REG;
						end
					end
					cwic_pkg::KIND_BUTTON, cwic_pkg::KIND_TAP: begin
						if (sts.btn_ok) begin
							cmd.accepted = 1'b1;
							if (sts.wake_cond) begin
								cmd.wake = 1'b1;
							end else if (!hold) begin
								if (sts.kind == cwic_pkg::KIND_BUTTON) begin
									cmd.op = cwic_pkg::OP_BUTTON;
								end else if (sts.tap_pending) begin
									// release the earlier tap first
									cmd.op     = cwic_pkg::OP_TAP_RELEASE;
									cmd.finish = 1'b0;
									state_d    = S_TAP2;
								end else begin
									cmd.op = cwic_pkg::OP_TAP_PRESS;
								end
							end
						end
					end
					cwic_pkg::KIND_WHEEL: begin
						if (!hold) begin
							cmd.op = cwic_pkg::OP_WHEEL;
						end
					end
					cwic_pkg::KIND_RELALL: begin
						if (sts.held_any) begin
							cmd.op = cwic_pkg::OP_RELEASE_ALL;
						end
					end
					cwic_pkg::KIND_TICK: begin
						if (sts.tick_due) begin
							cmd.op = cwic_pkg::OP_TICK;
						end
					end
					default: ;
				endcase
			end
			S_READ: begin
				cmd.op     = cwic_pkg::OP_READ_OUT;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			S_TAP2: begin
				cmd.op       = cwic_pkg::OP_TAP_PRESS;
				cmd.accepted = 1'b1;
				cmd.finish   = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`CWIC_ASSERT(a_accept_goes_busy, clk, arst_n, start && !busy |=> busy, "accepted word did not start")
	`CWIC_ASSERT(a_finish_only_busy, clk, arst_n, cmd.finish |-> busy, "finish while idle")
	`CWIC_ASSERT(a_tap2_after_release, clk, arst_n, (state_q == S_TAP2) |-> $past(cmd.op == cwic_pkg::OP_TAP_RELEASE), "second tap step without release")

endmodule

// File: rtl/core/cwic_dp.sv
`include "assert_macros.svh"

module cwic_dp #(
	parameter int REG_WORDS   = 32,
	parameter int QUEUE_DEPTH = 8,
	parameter int WHEEL_STEPS = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cwic_pkg::item_t   item,
	input  cwic_pkg::cmd_t    cmd,
	output cwic_pkg::sts_t    sts,
	output logic              done,
	output cwic_pkg::result_t result
);

	localparam int RW = $clog2(REG_WORDS);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = CW + 1;
	localparam int PW = $clog2(WHEEL_STEPS);
	// plus 128, the least step multiple covering a full negative delta
	localparam int WHEEL_BIAS = WHEEL_STEPS * ((128 + WHEEL_STEPS - 1) / WHEEL_STEPS) - 128;

	cwic_pkg::item_t   item_q;
	cwic_pkg::result_t result_q;
	logic              done_q;

	logic [4:0]                      bs_q, bs_d;
	logic [4:0]                      rm_q, rm_d;
	logic [cwic_pkg::DEADLINE_W-1:0] dl_q, dl_d;
	logic [PW-1:0]                   pos_q, pos_d, wheel_next;
	logic [QW-1:0]                   head_q, head_d, head_inc, q_waddr;
	logic [CW-1:0]                   count_q, count_d;
	logic                            irq_q, irq_d;
	logic [31:0]                     last_q;

	logic [31:0] rf_mem [REG_WORDS];
	logic [31:0] q_mem [QUEUE_DEPTH];
	logic [REG_WORDS-1:0] rf_vld_q;
	logic [31:0] rf_rd_q, q_rd_q;
	logic        rf_rd_vld_q;

	logic [5:0]    wadr;
	logic [RW-1:0] ridx;
	logic [4:0]    bit_v;
	logic          push_en, pop_en, rf_we, dup, do_push, full;
	logic [31:0]   push_word;
	logic [TW-1:0] tsum;
	logic [9:0]    wsum;
	logic [31:0]   rv, rshift, rmask, rdata;

	function automatic logic [31:0] st_of(input logic [4:0] bs);
		st_of = cwic_pkg::ST_BASE | {19'b0, bs, 8'b0};
	endfunction

	assign wadr  = item_q.offset[7:2];
	assign ridx  = item_q.offset[RW+1:2];
	assign bit_v = 5'b00001 << item_q.button;

	// status toward the controller
	always_comb begin
		sts.kind        = item_q.kind;
		sts.btn_ok      = (item_q.button <= cwic_pkg::MENU_CODE);
		sts.wake_cond   = (item_q.button == cwic_pkg::MENU_CODE) && item_q.in_standby &&
			((item_q.kind == cwic_pkg::KIND_TAP) || item_q.pressed);
		sts.win_ok      = ({1'b0, wadr} < 7'(REG_WORDS));
		sts.pop_addr    = (wadr == cwic_pkg::WADDR_POP) || (wadr == cwic_pkg::WADDR_STATUS);
		sts.tap_pending = (rm_q != '0);
		sts.tick_due    = (rm_q != '0) && ({1'b0, item_q.now_tick} >= dl_q);
		sts.held_any    = (bs_q != '0) || (rm_q != '0);
	end

	// wheel position: bias to nonnegative, then restoring reduction
	always_comb begin
		wsum = 10'(pos_q) + 10'({~item_q.wheel_delta[7], item_q.wheel_delta[6:0]}) +
			10'(WHEEL_BIAS);
		for (int k = 7; k >= 0; k--) begin
			if (32'(wsum) >= (WHEEL_STEPS << k)) begin
				wsum = wsum - 10'(WHEEL_STEPS << k);
			end
		end
		wheel_next = PW'(wsum);
	end

	// register write, pop, button, tap, wheel, release-all and tick updates
	always_comb begin
		bs_d      = bs_q;
		rm_d      = rm_q;
		dl_d      = dl_q;
		pos_d     = pos_q;
		push_en   = 1'b0;
		push_word = st_of(bs_q);
		pop_en    = 1'b0;
		rf_we     = 1'b0;
		case (cmd.op)
			cwic_pkg::OP_WRITE_REG: rf_we = 1'b1;
			cwic_pkg::OP_POP: pop_en = 1'b1;
			cwic_pkg::OP_BUTTON: begin
				bs_d      = item_q.pressed ? (bs_q | bit_v) : (bs_q & ~bit_v);
				push_en   = 1'b1;
				push_word = st_of(bs_d);
			end
			cwic_pkg::OP_TAP_RELEASE: begin
				bs_d      = bs_q & ~rm_q;
				push_en   = 1'b1;
				push_word = st_of(bs_d);
			end
			cwic_pkg::OP_TAP_PRESS: begin
				bs_d      = bs_q | bit_v;
				rm_d      = bit_v;
				dl_d      = cwic_pkg::DEADLINE_W'(item_q.now_tick) +
					cwic_pkg::DEADLINE_W'(item_q.tap_ticks);
				push_en   = 1'b1;
				push_word = st_of(bs_d);
			end
			cwic_pkg::OP_WHEEL: begin
				pos_d     = wheel_next;
				push_en   = 1'b1;
				push_word = st_of(bs_q) | cwic_pkg::ST_WHEEL | (32'(wheel_next) << 16);
			end
			cwic_pkg::OP_RELEASE_ALL: begin
				bs_d      = '0;
				rm_d      = '0;
				dl_d      = '0;
				push_en   = 1'b1;
				push_word = cwic_pkg::ST_BASE;
			end
			cwic_pkg::OP_TICK: begin
				bs_d      = bs_q & ~rm_q;
				rm_d      = '0;
				dl_d      = '0;
				push_en   = 1'b1;
				push_word = st_of(bs_d);
			end
			default: ;
		endcase
	end

	// status queue pointers; a repeat of the newest word is dropped
	always_comb begin
		dup      = (count_q != '0) && (last_q == push_word);
		do_push  = push_en && !dup;
		full     = (count_q == CW'(QUEUE_DEPTH));
		head_inc = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tsum     = TW'(head_q) + TW'(count_q);
		if (tsum >= TW'(QUEUE_DEPTH)) begin
			tsum = tsum - TW'(QUEUE_DEPTH);
		end
		// when full the oldest slot is overwritten
		q_waddr  = full ? head_q : tsum[QW-1:0];
		head_d   = head_q;
		count_d  = count_q;
		irq_d    = irq_q;
		if (do_push) begin
			irq_d = 1'b1;
			if (full) begin
				head_d = head_inc;
			end else begin
				count_d = count_q + 1'b1;
			end
		end
		if (pop_en) begin
			if (count_q != '0) begin
				head_d  = head_inc;
				count_d = count_q - 1'b1;
			end
			irq_d = (count_d != '0);
		end
	end

	// read word: shift by byte lane, mask by size
	always_comb begin
		rv = rf_rd_vld_q ? rf_rd_q : '0;
		if (wadr == cwic_pkg::WADDR_PENDING) begin
			if (count_q != '0) begin
				rv = rv | cwic_pkg::ST_PENDING;
			end
		end else if (wadr == cwic_pkg::WADDR_STATUS) begin
			rv = (count_q != '0) ? q_rd_q : st_of(bs_q);
		end
		rshift = rv >> {item_q.offset[1:0], 3'b000};
		case (item_q.access_size)
			cwic_pkg::SIZE_BYTE: rmask = 32'h0000_00ff;
			cwic_pkg::SIZE_HALF: rmask = 32'h0000_ffff;
			default:             rmask = 32'hffff_ffff;
		endcase
		rdata = sts.win_ok ? (rshift & rmask) : '0;
	end

	// control and small state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q        <= '0;
			rm_q        <= '0;
			dl_q        <= '0;
			pos_q       <= '0;
			head_q      <= '0;
			count_q     <= '0;
			irq_q       <= 1'b0;
			rf_vld_q    <= '0;
			rf_rd_vld_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			bs_q        <= bs_d;
			rm_q        <= rm_d;
			dl_q        <= dl_d;
			pos_q       <= pos_d;
			head_q      <= head_d;
			count_q     <= count_d;
			irq_q       <= irq_d;
			rf_rd_vld_q <= rf_vld_q[ridx];
			if (rf_we) begin
				rf_vld_q[ridx] <= 1'b1;
			end
			done_q      <= cmd.finish;
		end
	end

	// payload registers and memories
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (do_push) begin
			last_q           <= push_word;
			q_mem[q_waddr]   <= push_word;
		end
		q_rd_q <= q_mem[head_q];
		if (rf_we) begin
			rf_mem[ridx] <= item_q.write_data;
		end
		rf_rd_q <= rf_mem[ridx];
		if (cmd.finish) begin
			result_q.read_data     <= (cmd.op == cwic_pkg::OP_READ_OUT) ? rdata : '0;
			result_q.accepted      <= cmd.accepted;
			result_q.wake_request  <= cmd.wake;
			result_q.irq           <= irq_d;
			result_q.pending_count <= 4'(count_d);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`CWIC_ASSERT_ALWAYS(a_irq_tracks_count, clk, irq_q == (count_q != '0), "irq out of step with queue")
	`CWIC_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(QUEUE_DEPTH), "queue count overflow")
	`CWIC_ASSERT(a_tap_onehot, clk, arst_n, $onehot0(rm_q), "more than one tap pending")

endmodule

// File: rtl/core/click_wheel_input_controller_top.sv
// click-wheel input controller
// input channel: a word on item is taken at a rising edge where start is high
//   and busy is low; busy then stays high while the word is worked on
// output channel: one result word per input word, valid on result while done
//   is high for exactly one cycle; the receiver cannot hold it off
// done is registered from the exec state for most words, from the read state
//   for bus reads (the register file and status queue memories have a
//   registered read port) and from the second tap state for a tap that
//   replaces one (two pushes, one per cycle, through the single queue write port)
// busy drops in the cycle that done is high, so a new word can be taken then;
//   a new word is never taken while the last one is still being worked on
// configuration: APB register 0 at byte address 0 holds the hold switch;
//   write it only while no word is in flight
// reset: arst_n clears the register file (through per-word valid bits), the
//   queue pointers, button, tap, wheel and interrupt state at once; no
//   clearing pass is needed and a word may be taken right after reset
module click_wheel_input_controller_top #(
	parameter int REG_WORDS   = 32,
	parameter int QUEUE_DEPTH = 8,
	parameter int WHEEL_STEPS = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cwic_pkg::item_t   item,
	output logic              done,
	output cwic_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic           hold;
	cwic_pkg::cmd_t cmd;
	cwic_pkg::sts_t sts;

	// configuration register
	cwic_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.hold    (hold)
	);

	// sequencing
	cwic_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hold   (hold),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// state, queue and register file
	cwic_dp #(
		.REG_WORDS   (REG_WORDS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.WHEEL_STEPS (WHEEL_STEPS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule
